// ===== hdl/c8ic_pkg.sv =====
// Shared types, constants and tables for the CHIP-8 instruction core.
// No dependencies; used by c8ic_alu and chip8_instruction_core.
`timescale 1ns / 1ps
`default_nettype none
package c8ic_pkg;

  localparam int MEM_BYTES       = 4096;
  localparam int ADDR_W          = 12;
  localparam int SCREEN_COLUMNS  = 64;
  localparam int SCREEN_LINES    = 32;
  localparam int LINE_W          = 5;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int FONT_BYTES      = 80;

  localparam logic [15:0] RNG_SEED_RESET     = 16'hACE1;
  localparam logic [7:0]  TIMER_DIVIDE_RESET = 8'd10;
  localparam logic [11:0] START_ADDRESS      = 12'h200;
  localparam logic [15:0] LFSR_TAPS          = 16'hB400;

  localparam logic [1:0] CFG_RNG_SEED      = 2'd0;
  localparam logic [1:0] CFG_TIMER_DIVIDE  = 2'd1;
  localparam logic [1:0] CFG_START_ADDRESS = 2'd2;

  localparam logic [1:0] ITEM_WRITE = 2'd0;
  localparam logic [1:0] ITEM_EXEC  = 2'd1;
  localparam logic [1:0] ITEM_ROW   = 2'd2;
  localparam logic [1:0] ITEM_READ  = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_MEMRD, ST_ROWRD, ST_F0, ST_F1, ST_F2, ST_RA, ST_RB,
    ST_EX, ST_WX, ST_RET, ST_CLS, ST_D0, ST_D1, ST_D2, ST_DV, ST_BCD,
    ST_ST0, ST_ST1, ST_LD0, ST_LD1, ST_TICK, ST_DONE
  } state_t;

  typedef struct packed {
    logic       valid;
    logic       flag_valid;
    logic       flag;
    logic [7:0] res;
    logic [7:0] rnd;
    logic [7:0] hund;
    logic [7:0] tens;
    logic [7:0] ones;
  } alu_out_t;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] addr);
    logic [7:0] val;
    val = 8'd0;
    if (addr < ADDR_W'(FONT_BYTES)) begin
      val = FONT[addr[6:0]];
    end
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/c8ic_alu.sv =====
// Register arithmetic for 8XYn, random reduction and BCD digits.
// Depends on c8ic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module c8ic_alu (
  input  logic [3:0]         funct,
  input  logic [7:0]         a,
  input  logic [7:0]         b,
  input  logic [15:0]        lfsr_next,
  output c8ic_pkg::alu_out_t result
);

  logic [8:0] sum;
  logic [8:0] bsum;
  logic [7:0] bsum2;
  logic [7:0] rem;
  logic [14:0] prod;
  logic [7:0] tens;

  assign sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    result.valid      = 1'b1;
    result.flag_valid = 1'b1;
    result.flag       = 1'b0;
    result.res        = 8'd0;
    unique case (funct)
      4'h0: begin result.res = b;     result.flag_valid = 1'b0; end
      4'h1: begin result.res = a | b; result.flag_valid = 1'b0; end
      4'h2: begin result.res = a & b; result.flag_valid = 1'b0; end
      4'h3: begin result.res = a ^ b; result.flag_valid = 1'b0; end
      4'h4: begin result.res = sum[7:0]; result.flag = sum[8]; end
      4'h5: begin result.res = a - b; result.flag = (a >= b); end
      4'h6: begin result.res = {1'b0, a[7:1]}; result.flag = a[0]; end
      4'h7: begin result.res = b - a; result.flag = (b >= a); end
      4'hE: begin result.res = {a[6:0], 1'b0}; result.flag = a[7]; end
      default: begin
        result.valid      = 1'b0;
        result.flag_valid = 1'b0;
      end
    endcase
  end

  assign bsum  = {1'b0, lfsr_next[15:8]} + {1'b0, lfsr_next[7:0]};
  assign bsum2 = bsum[7:0] + {7'd0, bsum[8]};
  assign result.rnd = (bsum2 == 8'hFF) ? 8'd0 : bsum2;

  always_comb begin
    if (a >= 8'd200) begin
      result.hund = 8'd2;
      rem = a - 8'd200;
    end else if (a >= 8'd100) begin
      result.hund = 8'd1;
      rem = a - 8'd100;
    end else begin
      result.hund = 8'd0;
      rem = a;
    end
  end

  assign prod = {8'd0, rem[6:0]} * 15'd205;
  assign tens = {4'd0, prod[14:11]};
  assign result.tens = tens;
  assign result.ones = rem - {tens[4:0], 3'b000} - {tens[6:0], 1'b0};

endmodule
`default_nettype wire

// ===== hdl/chip8_instruction_core.sv =====
// CHIP-8 interpreter core: sequencer, main memory, screen, register file and stack.
// Depends on c8ic_pkg and c8ic_alu.
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser opcode, s_tdata item fields
// m_       out  m_tvalid/m_tready  m_tdata result fields
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// After reset a clearing pass loads the font and zeroes all state.
// The fetch and operand reads go through the memories' single read ports, and a
// sprite is drawn one line at a time.
// One item is in work at a time; the next is taken while a result waits in the
// output register.
`timescale 1ns / 1ps
`default_nettype none
module chip8_instruction_core #(
  parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // address, data_byte, row, key_down, key_index, pad
  input  logic [1:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // pc, halted, redraw, beep, waiting_key, row_pixels, read_data
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SPW = $clog2(STACK_DEPTH);
  localparam int AW  = c8ic_pkg::ADDR_W;
  localparam int LW  = c8ic_pkg::LINE_W;

  c8ic_pkg::state_t state, state_next;

  logic [7:0]  mem [c8ic_pkg::MEM_BYTES];
  logic [63:0] scr [c8ic_pkg::SCREEN_LINES];
  logic [7:0]  vreg [16];
  logic [11:0] stk [STACK_DEPTH];

  logic [AW-1:0] mem_raddr, mem_waddr;
  logic          mem_we;
  logic [7:0]    mem_wdata, mem_q;
  logic [LW-1:0] scr_raddr, scr_waddr;
  logic          scr_we;
  logic [63:0]   scr_wdata, scr_q;
  logic [3:0]    v_raddr, v_waddr;
  logic          v_we;
  logic [7:0]    v_wdata, v_q;
  logic [SPW-1:0] stk_raddr, stk_waddr;
  logic          stk_we;
  logic [11:0]   stk_wdata, stk_q;

  logic [AW-1:0] cnt;
  logic [11:0]   pc;
  logic [15:0]   ireg;
  logic [SPW-1:0] sp;
  logic [7:0]    delay_count, sound_count, tick, tdiv;
  logic [15:0]   lfsr;
  logic          halt_flag, redraw_flag;
  logic [7:0]    op_hi, op_lo, a, b, res_hold, sprite;
  logic          collide;
  logic [1:0]    item_op;
  logic          key_down_r;
  logic [3:0]    key_r;
  logic          r_beep, r_wait, r_snap;
  logic [63:0]   r_pix;
  logic [7:0]    r_rd;

  logic [AW-1:0] in_addr;
  logic [7:0]    in_data;
  logic [LW-1:0] in_row;

  assign in_addr = s_tdata[11:0];
  assign in_data = s_tdata[19:12];
  assign in_row  = s_tdata[24:20];

  logic [3:0]  kind, x, y, n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic        is_halt, is_cls, is_ret;
  assign kind    = op_hi[7:4];
  assign x       = op_hi[3:0];
  assign y       = op_lo[7:4];
  assign n       = op_lo[3:0];
  assign nn      = op_lo;
  assign nnn     = {op_hi[3:0], op_lo};
  assign is_halt = ({op_hi, op_lo} == 16'h0000);
  assign is_cls  = ({op_hi, op_lo} == 16'h00E0);
  assign is_ret  = ({op_hi, op_lo} == 16'h00EE);

  logic [SPW-1:0] sp_inc, sp_dec;
  assign sp_inc = (sp == SPW'(STACK_DEPTH - 1)) ? '0 : sp + 1'b1;
  assign sp_dec = (sp == '0) ? SPW'(STACK_DEPTH - 1) : sp - 1'b1;

  logic key_hit, skip;
  assign key_hit = key_down_r && (a < 8'd16) && (a[3:0] == key_r);
  always_comb begin
    unique case (kind)
      4'h3:    skip = (a == nn);
      4'h4:    skip = (a != nn);
      4'h5:    skip = (a == b);
      4'h9:    skip = (a != b);
      4'hE:    skip = (nn == 8'h9E) ? key_hit : !key_hit;
      default: skip = 1'b0;
    endcase
  end

  logic [15:0] lfsr_next;
  assign lfsr_next = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? c8ic_pkg::LFSR_TAPS : 16'h0000);

  logic [16:0] i_sum;
  assign i_sum = {1'b0, ireg} + {9'd0, a};

  logic [AW-1:0] addr_i;
  assign addr_i = ireg[AW-1:0] + cnt;

  // Sprite placement: pixels run on across the right edge into the next line.
  logic [7:0]    yl;
  logic [10:0]   pos;
  logic [LW-1:0] r0, r1;
  logic [7:0]    mask_src;
  logic [127:0]  mask;
  assign yl       = b + {4'd0, cnt[3:0]};
  assign pos      = {yl[4:0], 6'd0} + {3'd0, a};
  assign r0       = pos[10:6];
  assign r1       = r0 + 1'b1;
  assign mask_src = (state == c8ic_pkg::ST_D1) ? mem_q : sprite;
  assign mask     = {mask_src, 120'd0} >> pos[5:0];

  c8ic_pkg::alu_out_t alu;
  c8ic_alu u_alu (
    .funct    (n),
    .a        (a),
    .b        (b),
    .lfsr_next(lfsr_next),
    .result   (alu)
  );

  assign s_tready  = (state == c8ic_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr[scr_waddr] <= scr_wdata;
    end
    scr_q <= scr[scr_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vreg[v_waddr] <= v_wdata;
    end
    v_q <= vreg[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_waddr] <= stk_wdata;
    end
    stk_q <= stk[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= c8ic_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_raddr  = pc;
    mem_we     = 1'b0;
    mem_waddr  = addr_i;
    mem_wdata  = 8'd0;
    scr_raddr  = r0;
    scr_we     = 1'b0;
    scr_waddr  = r0;
    scr_wdata  = 64'd0;
    v_raddr    = x;
    v_we       = 1'b0;
    v_waddr    = x;
    v_wdata    = 8'd0;
    stk_raddr  = sp_dec;
    stk_we     = 1'b0;
    stk_waddr  = sp;
    stk_wdata  = pc;
    unique case (state)
      c8ic_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = c8ic_pkg::font_byte(cnt);
        scr_we    = 1'b1;
        scr_waddr = cnt[LW-1:0];
        v_we      = 1'b1;
        v_waddr   = cnt[3:0];
        stk_we    = (cnt < AW'(STACK_DEPTH));
        stk_waddr = cnt[SPW-1:0];
        stk_wdata = 12'd0;
        if (cnt == {AW{1'b1}}) begin
          state_next = c8ic_pkg::ST_IDLE;
        end
      end
      c8ic_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tuser)
            c8ic_pkg::ITEM_WRITE: begin
              mem_we     = 1'b1;
              mem_waddr  = in_addr;
              mem_wdata  = in_data;
              state_next = c8ic_pkg::ST_DONE;
            end
            c8ic_pkg::ITEM_EXEC: begin
              state_next = halt_flag ? c8ic_pkg::ST_DONE : c8ic_pkg::ST_F0;
            end
            c8ic_pkg::ITEM_ROW: begin
              scr_raddr  = in_row;
              state_next = c8ic_pkg::ST_ROWRD;
            end
            c8ic_pkg::ITEM_READ: begin
              mem_raddr  = in_addr;
              state_next = c8ic_pkg::ST_MEMRD;
            end
          endcase
        end
      end
      c8ic_pkg::ST_MEMRD: state_next = c8ic_pkg::ST_DONE;
      c8ic_pkg::ST_ROWRD: state_next = c8ic_pkg::ST_DONE;
      c8ic_pkg::ST_F0:    state_next = c8ic_pkg::ST_F1;
      c8ic_pkg::ST_F1: begin
        mem_raddr  = pc + 12'd1;
        state_next = c8ic_pkg::ST_F2;
      end
      c8ic_pkg::ST_F2: state_next = c8ic_pkg::ST_RA;
      c8ic_pkg::ST_RA: begin
        v_raddr    = (kind == 4'hB) ? 4'h0 : y;
        state_next = c8ic_pkg::ST_RB;
      end
      c8ic_pkg::ST_RB: state_next = c8ic_pkg::ST_EX;
      c8ic_pkg::ST_EX: begin
        state_next = c8ic_pkg::ST_TICK;
        if (is_halt) begin
          state_next = c8ic_pkg::ST_TICK;
        end else if (is_cls) begin
          state_next = c8ic_pkg::ST_CLS;
        end else if (is_ret) begin
          state_next = c8ic_pkg::ST_RET;
        end else begin
          unique case (kind)
            4'h2: stk_we = 1'b1;
            4'h6: begin v_we = 1'b1; v_wdata = nn; end
            4'h7: begin v_we = 1'b1; v_wdata = a + nn; end
            4'h8: begin
              if (alu.valid) begin
                v_we = 1'b1;
                if (alu.flag_valid) begin
                  v_waddr    = 4'hF;
                  v_wdata    = {7'd0, alu.flag};
                  state_next = c8ic_pkg::ST_WX;
                end else begin
                  v_wdata = alu.res;
                end
              end
            end
            4'hC: begin v_we = 1'b1; v_wdata = alu.rnd & nn; end
            4'hD: state_next = (n == 4'd0) ? c8ic_pkg::ST_DV : c8ic_pkg::ST_D0;
            4'hF: begin
              unique case (nn)
                8'h07: begin v_we = 1'b1; v_wdata = delay_count; end
                8'h0A: begin v_we = key_down_r; v_wdata = {4'd0, key_r}; end
                8'h1E: begin
                  v_we    = 1'b1;
                  v_waddr = 4'hF;
                  v_wdata = {7'd0, (i_sum > 17'h00FFF)};
                end
                8'h33: state_next = c8ic_pkg::ST_BCD;
                8'h55: state_next = c8ic_pkg::ST_ST0;
                8'h65: state_next = c8ic_pkg::ST_LD0;
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      c8ic_pkg::ST_WX: begin
        v_we       = 1'b1;
        v_wdata    = res_hold;
        state_next = c8ic_pkg::ST_TICK;
      end
      c8ic_pkg::ST_RET: state_next = c8ic_pkg::ST_TICK;
      c8ic_pkg::ST_CLS: begin
        scr_we    = 1'b1;
        scr_waddr = cnt[LW-1:0];
        if (cnt[LW-1:0] == {LW{1'b1}}) begin
          state_next = c8ic_pkg::ST_TICK;
        end
      end
      c8ic_pkg::ST_D0: begin
        mem_raddr  = addr_i;
        state_next = c8ic_pkg::ST_D1;
      end
      c8ic_pkg::ST_D1: begin
        scr_we     = 1'b1;
        scr_wdata  = scr_q ^ mask[127:64];
        scr_raddr  = r1;
        state_next = c8ic_pkg::ST_D2;
      end
      c8ic_pkg::ST_D2: begin
        scr_we     = 1'b1;
        scr_waddr  = r1;
        scr_wdata  = scr_q ^ mask[63:0];
        state_next = (cnt[3:0] == n - 4'd1) ? c8ic_pkg::ST_DV : c8ic_pkg::ST_D0;
      end
      c8ic_pkg::ST_DV: begin
        v_we       = 1'b1;
        v_waddr    = 4'hF;
        v_wdata    = {7'd0, collide};
        state_next = c8ic_pkg::ST_TICK;
      end
      c8ic_pkg::ST_BCD: begin
        mem_we = 1'b1;
        unique case (cnt[1:0])
          2'd0:    mem_wdata = alu.hund;
          2'd1:    mem_wdata = alu.tens;
          default: mem_wdata = alu.ones;
        endcase
        if (cnt[1:0] == 2'd2) begin
          state_next = c8ic_pkg::ST_TICK;
        end
      end
      c8ic_pkg::ST_ST0: begin
        v_raddr    = cnt[3:0];
        state_next = c8ic_pkg::ST_ST1;
      end
      c8ic_pkg::ST_ST1: begin
        mem_we     = 1'b1;
        mem_wdata  = v_q;
        state_next = (cnt[3:0] == x) ? c8ic_pkg::ST_TICK : c8ic_pkg::ST_ST0;
      end
      c8ic_pkg::ST_LD0: begin
        mem_raddr  = addr_i;
        state_next = c8ic_pkg::ST_LD1;
      end
      c8ic_pkg::ST_LD1: begin
        v_we       = 1'b1;
        v_waddr    = cnt[3:0];
        v_wdata    = mem_q;
        state_next = (cnt[3:0] == x) ? c8ic_pkg::ST_TICK : c8ic_pkg::ST_LD0;
      end
      c8ic_pkg::ST_TICK: state_next = c8ic_pkg::ST_DONE;
      c8ic_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = c8ic_pkg::ST_IDLE;
        end
      end
      default: state_next = c8ic_pkg::ST_IDLE;
    endcase
  end

  logic [7:0] div;
  logic [7:0] t0;
  logic [8:0] t1;
  assign div = (tdiv == 8'd0) ? 8'd1 : tdiv;
  assign t0  = (tick >= div) ? 8'd0 : tick;
  assign t1  = {1'b0, t0} + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      pc          <= c8ic_pkg::START_ADDRESS;
      ireg        <= 16'd0;
      sp          <= '0;
      delay_count <= 8'd0;
      sound_count <= 8'd0;
      tick        <= 8'd0;
      tdiv        <= c8ic_pkg::TIMER_DIVIDE_RESET;
      lfsr        <= c8ic_pkg::RNG_SEED_RESET;
      halt_flag   <= 1'b0;
      redraw_flag <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        c8ic_pkg::ST_CLEAR: cnt <= cnt + 1'b1;
        c8ic_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            item_op    <= s_tuser;
            key_down_r <= s_tdata[25];
            key_r      <= s_tdata[29:26];
            r_beep     <= 1'b0;
            r_wait     <= 1'b0;
            r_pix      <= 64'd0;
            r_rd       <= 8'd0;
          end
        end
        c8ic_pkg::ST_MEMRD: r_rd <= mem_q;
        c8ic_pkg::ST_ROWRD: begin
          r_pix       <= scr_q;
          r_snap      <= redraw_flag;
          redraw_flag <= 1'b0;
        end
        c8ic_pkg::ST_F1: op_hi <= mem_q;
        c8ic_pkg::ST_F2: op_lo <= mem_q;
        c8ic_pkg::ST_RA: a <= v_q;
        c8ic_pkg::ST_RB: b <= v_q;
        c8ic_pkg::ST_EX: begin
          cnt <= '0;
          if (is_halt) begin
            halt_flag <= 1'b1;
          end else if (is_ret) begin
            sp <= sp_dec;
          end else begin
            pc <= pc + 12'd2;
            unique case (kind)
              4'h1: pc <= nnn;
              4'h2: begin sp <= sp_inc; pc <= nnn; end
              4'h3, 4'h4, 4'h5, 4'h9: pc <= pc + (skip ? 12'd4 : 12'd2);
              4'h8: res_hold <= alu.res;
              4'hA: ireg <= {4'd0, nnn};
              4'hB: pc <= {4'd0, b} + nnn;
              4'hC: lfsr <= lfsr_next;
              4'hD: collide <= 1'b0;
              4'hE: begin
                if (nn == 8'h9E || nn == 8'hA1) begin
                  pc <= pc + (skip ? 12'd4 : 12'd2);
                end
              end
              4'hF: begin
                unique case (nn)
                  8'h0A: begin
                    if (!key_down_r) begin
                      pc     <= pc;
                      r_wait <= 1'b1;
                    end
                  end
                  8'h15: delay_count <= a;
                  8'h18: sound_count <= a;
                  8'h1E: ireg <= i_sum[15:0];
                  8'h29: ireg <= {6'd0, a, 2'b00} + {8'd0, a};
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
        c8ic_pkg::ST_RET: pc <= stk_q + 12'd2;
        c8ic_pkg::ST_CLS: begin
          cnt         <= cnt + 1'b1;
          redraw_flag <= 1'b1;
        end
        c8ic_pkg::ST_D1: begin
          sprite  <= mem_q;
          collide <= collide | (|(scr_q & mask[127:64]));
        end
        c8ic_pkg::ST_D2: begin
          collide <= collide | (|(scr_q & mask[63:0]));
          cnt     <= cnt + 1'b1;
        end
        c8ic_pkg::ST_DV:  redraw_flag <= 1'b1;
        c8ic_pkg::ST_BCD: cnt <= cnt + 1'b1;
        c8ic_pkg::ST_ST1: cnt <= cnt + 1'b1;
        c8ic_pkg::ST_LD1: cnt <= cnt + 1'b1;
        c8ic_pkg::ST_TICK: begin
          if (t0 == 8'd0) begin
            if (delay_count != 8'd0) begin
              delay_count <= delay_count - 8'd1;
            end
            if (sound_count != 8'd0) begin
              sound_count <= sound_count - 8'd1;
              r_beep      <= 1'b1;
            end
          end
          tick <= (t1 >= {1'b0, div}) ? 8'd0 : t1[7:0];
        end
        c8ic_pkg::ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {r_rd, r_pix, r_wait, r_beep,
                         (item_op == c8ic_pkg::ITEM_ROW) ? r_snap : redraw_flag,
                         halt_flag, pc};
          end
        end
        default: ;
      endcase
      if (cfg_valid) begin
        unique case (cfg_index)
          c8ic_pkg::CFG_RNG_SEED:     lfsr <= cfg_data;
          c8ic_pkg::CFG_TIMER_DIVIDE: tdiv <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/chip8_core_checker.sv =====
// Checker for the CHIP-8 instruction core: watches the item, result and register channels,
// keeps its own copy of the core's state and compares each result with the prediction.
// Depends on c8ic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chip8_core_checker #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [87:0] m_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               pending,
  output int               failures,
  output int               results_seen,
  output int               draws_seen
);
  import c8ic_pkg::*;

  typedef struct {
    logic [11:0] pc;
    logic        halted;
    logic        redraw;
    logic        beep;
    logic        waiting;
    logic [63:0] pixels;
    logic [7:0]  rdata;
  } core_result_t;

  core_result_t expected_results[$];

  logic [7:0]  mem [MEM_BYTES];
  logic [63:0] screen [SCREEN_LINES];
  logic [7:0]  vreg [16];
  logic [11:0] call_stack [STACK_DEPTH];
  logic [15:0] ireg, lfsr, seed;
  logic [11:0] pcr, start_addr;
  int unsigned sp;
  logic [7:0]  delay_cnt, sound_cnt, tick_cnt, tick_div;
  logic        halt_flag, redraw_flag;

  task automatic reset_model();
    for (int i = 0; i < MEM_BYTES; i++) mem[i] = (i < FONT_BYTES) ? FONT[i] : 8'd0;
    for (int i = 0; i < SCREEN_LINES; i++) screen[i] = '0;
    for (int i = 0; i < 16; i++) vreg[i] = '0;
    for (int i = 0; i < STACK_DEPTH; i++) call_stack[i] = '0;
    seed = RNG_SEED_RESET;
    tick_div = TIMER_DIVIDE_RESET;
    start_addr = START_ADDRESS;
    ireg = '0;
    pcr = start_addr;
    sp = 0;
    delay_cnt = '0;
    sound_cnt = '0;
    tick_cnt = '0;
    lfsr = seed;
    halt_flag = 1'b0;
    redraw_flag = 1'b0;
  endtask

  task automatic draw_sprite(input logic [7:0] xpos, input logic [7:0] ypos,
                             input logic [3:0] height);
    logic [7:0] bits;
    int unsigned idx;
    vreg[15] = 8'd0;
    for (int ln = 0; ln < height; ln++) begin
      bits = mem[12'(ireg + ln)];
      for (int col = 0; col < 8; col++) begin
        if (bits[7-col]) begin
          idx = (xpos + col + (ypos + ln) * 64) % 2048;
          if (screen[idx / 64][63 - (idx % 64)]) vreg[15] = 8'd1;
          screen[idx / 64][63 - (idx % 64)] ^= 1'b1;
        end
      end
    end
    redraw_flag = 1'b1;
    draws_seen++;
  endtask

  task automatic run_instruction(input logic down, input logic [3:0] key, output logic stalled);
    logic [15:0] instr;
    logic [3:0]  x, y;
    logic [7:0]  nn, a, b;
    logic [11:0] nnn;
    logic [16:0] sum;
    logic        advance, skip, pressed;
    instr = {mem[pcr], mem[12'(pcr + 12'd1)]};
    x = instr[11:8];
    y = instr[7:4];
    nn = instr[7:0];
    nnn = instr[11:0];
    a = vreg[x];
    b = vreg[y];
    advance = 1'b1;
    skip = 1'b0;
    stalled = 1'b0;
    pressed = down && a < 8'd16 && a[3:0] == key;
    if (instr == 16'h0000) begin
      halt_flag = 1'b1;
      advance = 1'b0;
    end else if (instr == 16'h00E0) begin
      for (int i = 0; i < SCREEN_LINES; i++) screen[i] = '0;
      redraw_flag = 1'b1;
    end else if (instr == 16'h00EE) begin
      sp = (sp + STACK_DEPTH - 1) % STACK_DEPTH;
      pcr = call_stack[sp] + 12'd2;
      advance = 1'b0;
    end else begin
      case (instr[15:12])
        4'h1: begin
          pcr = nnn;
          advance = 1'b0;
        end
        4'h2: begin
          call_stack[sp] = pcr;
          sp = (sp + 1) % STACK_DEPTH;
          pcr = nnn;
          advance = 1'b0;
        end
        4'h3: skip = (a == nn);
        4'h4: skip = (a != nn);
        4'h5: skip = (a == b);
        4'h6: vreg[x] = nn;
        4'h7: vreg[x] = a + nn;
        4'h8: begin
          case (instr[3:0])
            4'h0: vreg[x] = b;
            4'h1: vreg[x] = a | b;
            4'h2: vreg[x] = a & b;
            4'h3: vreg[x] = a ^ b;
            4'h4: begin
              vreg[15] = {7'd0, (9'(a) + 9'(b)) > 9'h0FF};
              vreg[x] = a + b;
            end
            4'h5: begin
              vreg[15] = {7'd0, a >= b};
              vreg[x] = a - b;
            end
            4'h6: begin
              vreg[15] = {7'd0, a[0]};
              vreg[x] = a >> 1;
            end
            4'h7: begin
              vreg[15] = {7'd0, b >= a};
              vreg[x] = b - a;
            end
            4'hE: begin
              vreg[15] = {7'd0, a[7]};
              vreg[x] = a << 1;
            end
            default: ;
          endcase
        end
        4'h9: skip = (a != b);
        4'hA: ireg = {4'd0, nnn};
        4'hB: begin
          pcr = 12'(vreg[0] + nnn);
          advance = 1'b0;
        end
        4'hC: begin
          if (lfsr[0]) lfsr = (lfsr >> 1) ^ LFSR_TAPS;
          else lfsr = lfsr >> 1;
          vreg[x] = 8'(lfsr % 255) & nn;
        end
        4'hD: draw_sprite(a, b, instr[3:0]);
        4'hE: begin
          if (nn == 8'h9E) skip = pressed;
          else if (nn == 8'hA1) skip = !pressed;
        end
        4'hF: begin
          case (nn)
            8'h07: vreg[x] = delay_cnt;
            8'h0A: begin
              if (!down) begin
                stalled = 1'b1;
                advance = 1'b0;
              end else begin
                vreg[x] = {4'd0, key};
              end
            end
            8'h15: delay_cnt = a;
            8'h18: sound_cnt = a;
            8'h1E: begin
              sum = 17'(ireg) + 17'(a);
              vreg[15] = {7'd0, sum > 17'h0FFF};
              ireg = sum[15:0];
            end
            8'h29: ireg = 16'(a) * 16'd5;
            8'h33: begin
              mem[12'(ireg)] = a / 100;
              mem[12'(ireg + 16'd1)] = (a / 10) % 10;
              mem[12'(ireg + 16'd2)] = a % 10;
            end
            8'h55: for (int i = 0; i <= x; i++) mem[12'(ireg + i)] = vreg[i];
            8'h65: for (int i = 0; i <= x; i++) vreg[i] = mem[12'(ireg + i)];
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    if (advance) pcr = pcr + (skip ? 12'd4 : 12'd2);
  endtask

  task automatic predict_item(input logic [1:0] op, input logic [31:0] fields);
    core_result_t res;
    logic [7:0] div;
    res = '{default: '0};
    case (op)
      ITEM_WRITE: mem[fields[11:0]] = fields[19:12];
      ITEM_READ:  res.rdata = mem[fields[11:0]];
      ITEM_EXEC: begin
        if (!halt_flag) begin
          div = (tick_div == 0) ? 8'd1 : tick_div;
          run_instruction(fields[25], fields[29:26], res.waiting);
          if (tick_cnt >= div) tick_cnt = 0;
          if (tick_cnt == 0) begin
            if (delay_cnt != 0) delay_cnt--;
            if (sound_cnt != 0) begin
              res.beep = 1'b1;
              sound_cnt--;
            end
          end
          tick_cnt = (9'(tick_cnt) + 9'd1 >= 9'(div)) ? 8'd0 : tick_cnt + 8'd1;
        end
      end
      default: ;
    endcase
    res.redraw = redraw_flag;
    if (op == ITEM_ROW) begin
      res.pixels = screen[fields[24:20]];
      redraw_flag = 1'b0;
    end
    res.pc = pcr;
    res.halted = halt_flag;
    expected_results.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      failures++;
    end
  endtask

  task automatic check_result();
    core_result_t res;
    if (expected_results.size() == 0) begin
      $error("result with no expectation waiting: %0h", m_tdata);
      failures++;
    end else begin
      res = expected_results.pop_front();
      check_field("pc", 64'(res.pc), 64'(m_tdata[11:0]));
      check_field("halted", 64'(res.halted), 64'(m_tdata[12]));
      check_field("redraw", 64'(res.redraw), 64'(m_tdata[13]));
      check_field("beep", 64'(res.beep), 64'(m_tdata[14]));
      check_field("waiting_key", 64'(res.waiting), 64'(m_tdata[15]));
      check_field("row_pixels", res.pixels, m_tdata[79:16]);
      check_field("read_data", 64'(res.rdata), 64'(m_tdata[87:80]));
    end
    results_seen++;
  endtask

  initial begin
    failures = 0;
    results_seen = 0;
    draws_seen = 0;
    reset_model();
  end

  assign pending = expected_results.size();

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RNG_SEED: begin
            seed = cfg_data;
            lfsr = cfg_data;
          end
          CFG_TIMER_DIVIDE:  tick_div = cfg_data[7:0];
          CFG_START_ADDRESS: start_addr = cfg_data[11:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
    end
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the CHIP-8 instruction core testbench: clock, reset, item stimulus with idling,
// register writes and the verdict. Depends on c8ic_pkg, chip8_instruction_core
// and chip8_core_checker.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import c8ic_pkg::*;

  localparam int PROG_BASE = 12'h200;
  localparam int PROG_END  = 12'h27E;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = ITEM_WRITE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_RNG_SEED;
  logic [15:0] cfg_data = '0;

  int pending, failures, results_seen, draws_seen;
  int idle_mode = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  chip8_instruction_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  chip8_core_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .failures(failures), .results_seen(results_seen),
    .draws_seen(draws_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls in modes 2 and 3, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request <= 1'b0;
      hold_left <= 300;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (idle_mode == 2) begin
      m_tready <= ($urandom_range(99) >= 63);
    end else if (idle_mode == 3) begin
      m_tready <= ($urandom_range(99) >= 24);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("chip8_instruction_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [11:0] addr,
                           input logic [7:0] data, input logic [4:0] row,
                           input logic key_down, input logic [3:0] key_index);
    int idle_pct;
    idle_pct = (idle_mode == 1) ? 63 : (idle_mode == 3) ? 24 : 0;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {2'b00, key_index, key_down, row, data, addr};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_exec(input logic key_down, input logic [3:0] key_index);
    send_item(ITEM_EXEC, 12'($urandom), 8'($urandom), 5'($urandom), key_down, key_index);
  endtask

  task automatic write_byte(input logic [11:0] addr, input logic [7:0] data);
    send_item(ITEM_WRITE, addr, data, 5'($urandom), 1'($urandom), 4'($urandom));
  endtask

  task automatic write_word(input logic [11:0] addr, input logic [15:0] word);
    write_byte(addr, word[15:8]);
    write_byte(addr + 12'd1, word[7:0]);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] seed, input logic [7:0] divide,
                           input logic [11:0] start);
    wait_idle();
    write_reg(CFG_RNG_SEED, seed);
    write_reg(CFG_TIMER_DIVIDE, {8'd0, divide});
    write_reg(CFG_START_ADDRESS, {4'd0, start});
  endtask

  // Random instruction; jump and call targets stay in the program area and stores
  // mostly land above it.
  function automatic logic [15:0] random_instr();
    logic [3:0]  x, y;
    logic [7:0]  nn;
    logic [11:0] target;
    logic [3:0]  alu_ops [10] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE, 4'h9};
    x = 4'($urandom);
    y = 4'($urandom);
    nn = 8'($urandom);
    target = 12'(PROG_BASE + 2 * $urandom_range(0, 62));
    case ($urandom_range(31))
      0: return 16'h00E0;
      1: return ($urandom_range(3) == 0) ? 16'h00EE : {4'h6, x, nn};
      2: return {4'h1, target};
      3: return {4'h2, target};
      4: return {4'h3, x, nn};
      5: return {4'h4, x, nn};
      6: return {4'h5, x, y, 4'h0};
      7: return {4'h9, x, y, 4'h0};
      8, 9: return {4'h6, x, nn};
      10: return {4'h7, x, nn};
      11, 12, 13: return {4'h8, x, y, alu_ops[$urandom_range(9)]};
      14: return {4'hA, 12'($urandom_range(12'h300, 12'hFFF))};
      15: return ($urandom_range(3) == 0) ? {4'hB, 12'(PROG_BASE)} : {4'h7, x, nn};
      16: return {4'hC, x, nn};
      17, 18: return {4'hD, x, y, 4'($urandom)};
      19: return {4'hE, x, 8'h9E};
      20: return {4'hE, x, 8'hA1};
      21: return {4'hE, x, nn};
      22: return {4'hF, x, 8'h07};
      23: return {4'hF, x, 8'h0A};
      24: return {4'hF, x, 8'h15};
      25: return {4'hF, x, 8'h18};
      26: return {4'hF, x, 8'h1E};
      27: return {4'hF, x, 8'h29};
      28: return {4'hF, x, 8'h33};
      29: return {4'hF, x, 8'h55};
      30: return {4'hF, x, 8'h65};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_program(input int from);
    for (int a = from; a < PROG_END; a += 2) write_word(12'(a), random_instr());
    write_word(12'(PROG_END), {4'h1, 12'(PROG_BASE)});
    write_word(12'(PROG_END + 2), {4'h1, 12'(PROG_BASE)});
  endtask

  task automatic random_traffic(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_exec(1'($urandom), 4'($urandom));
      end else if (pick < 82) begin
        send_item(ITEM_ROW, 12'($urandom), 8'($urandom), 5'($urandom), 1'($urandom),
                  4'($urandom));
      end else if (pick < 94) begin
        send_item(ITEM_READ, 12'($urandom), 8'($urandom), 5'($urandom), 1'($urandom),
                  4'($urandom));
      end else begin
        write_byte(12'($urandom_range(12'h300, 12'hFFF)), 8'($urandom));
      end
    end
  endtask

  logic [15:0] directed_prog [] = '{
    16'h60FF, 16'h6101, 16'h8014, 16'h6005, 16'h8015, 16'h8017, 16'h8F06, 16'h800E,
    16'h00E0, 16'hA000, 16'hD015, 16'hD015, 16'hD010, 16'hC0FF, 16'h6203, 16'hF218,
    16'hF215, 16'hF307, 16'hF029, 16'hA300, 16'hF233, 16'hF355, 16'hF365, 16'hFF1E,
    16'hE19E, 16'h6000, 16'hE1A1, 16'hF40A, 16'h223C, 16'h1240, 16'h00EE, 16'h1240
  };

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: extremes of the registers and many instruction classes.
    configure(16'd1, 8'd1, 12'd0);
    for (int i = 0; i < directed_prog.size(); i++)
      write_word(12'(PROG_BASE + 2 * i), directed_prog[i]);
    load_program(PROG_BASE + 2 * directed_prog.size());
    for (int i = 0; i < 24; i++) send_exec(1'b1, 4'd1);
    send_exec(1'b1, 4'd1);
    send_exec(1'b1, 4'd1);
    send_exec(1'b0, 4'd0);
    send_exec(1'b1, 4'd15);
    for (int i = 0; i < 3; i++) send_exec(1'b1, 4'd0);
    send_item(ITEM_ROW, 12'h000, 8'h00, 5'd0, 1'b0, 4'd0);
    send_item(ITEM_ROW, 12'hFFF, 8'hFF, 5'd31, 1'b1, 4'd15);
    send_item(ITEM_READ, 12'h300, 8'h00, 5'd0, 1'b0, 4'd0);
    send_item(ITEM_READ, 12'hFFF, 8'h00, 5'd0, 1'b0, 4'd0);
    write_byte(12'hFFF, 8'hFF);

    // Random phases, one per idling pattern, each with its own register setting.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: configure(16'hFFFF, 8'd255, 12'hFFF);
        1: configure(16'd0, 8'd0, 12'h200);
        2: configure(16'hACE1, 8'd3, 12'h123);
        default: configure(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)),
                           12'($urandom));
      endcase
      idle_mode = phase;
      if (phase > 0) load_program(PROG_BASE);
      if (phase == 1) hold_request = 1'b1;
      random_traffic(250);
    end

    // Halt: clear the program area, run on, then access memory while halted.
    idle_mode = 0;
    for (int a = PROG_BASE; a < PROG_END + 4; a++) write_byte(12'(a), 8'h00);
    for (int i = 0; i < 6; i++) send_exec(1'($urandom), 4'($urandom));
    random_traffic(20);

    wait_idle();
    repeat (100) @(posedge clk);
    $display("Checked %0d results over 5 register settings and 4 idling patterns.",
             results_seen);
    $display("Sprite draws predicted: %0d.", draws_seen);
    if (failures == 0) begin
      $display("chip8_instruction_core regression: pass");
    end else begin
      $display("chip8_instruction_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/c8ic_pkg.sv
hdl/c8ic_alu.sv
hdl/chip8_instruction_core.sv
tb/chip8_core_checker.sv
tb/testbench.sv
